[sv/sbc_pkg.sv]
// shared types and constants of the splitter bin counter
`default_nettype none

package sbc_pkg;

    localparam int KEY_FIELD_W = 63;
    localparam int SIDX_W      = 6;
    localparam int BIN_IDX_W   = 6;
    localparam int COUNT_W     = 32;
    localparam int NBINS_W     = 7;
    localparam int MODE_W      = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EMIT  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [SIDX_W-1:0]      splitter_index;
        logic [KEY_FIELD_W-1:0] key_value;
    } t_in_item;

    typedef struct packed {
        logic [BIN_IDX_W-1:0] bin_index;
        logic [COUNT_W-1:0]   bin_count;
        logic                 last_bin;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_EMIT_RD,
        ST_EMIT_WR
    } t_state;

    // count memory controls
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_all;
    } t_cnt_ctl;

endpackage

`default_nettype wire

[sv/splitter_bin_counter.sv]
// top level: splitter bin histogram sequencer around key and count memories
//
//  channel   direction  handshake              payload
//  in        input      i_valid / o_ready      i_in  (sbc_pkg::t_in_item)
//  out       output     o_valid / i_ready      o_out (sbc_pkg::t_out_item)
//  cfg       input      i_cfg_we               i_cfg_wdata (num_bins)
//
// load splitter: one key memory write. count key: the pointer skips bins,
// one splitter memory read per bin examined; nothing read once it is parked.
// emit: a count read and an output load for each bin in use, with the load
// held while the output stalls.
// reset clears the bin pointer, the count valid flops and the output register;
// no clearing pass. the next transaction is taken once the sequencer is idle,
// also while an emitted result still waits in the output register.
`default_nettype none

module splitter_bin_counter #(
    parameter int MAX_BINS = 64,
    parameter int KEY_BITS = 63
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [sbc_pkg::NBINS_W-1:0]   i_cfg_wdata,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire sbc_pkg::t_in_item             i_in,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output sbc_pkg::t_out_item                 o_out
);

    localparam int CUR_W  = $clog2(MAX_BINS + 1);
    localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    sbc_pkg::t_state r_state, n_state;

    logic [sbc_pkg::NBINS_W-1:0] r_num_bins;
    logic [CUR_W-1:0]            r_cur, n_cur;
    logic [CUR_W-1:0]            r_idx, n_idx;
    logic [KEY_BITS-1:0]         r_key, n_key;
    logic                        r_out_vld;
    sbc_pkg::t_out_item          r_out;

    logic [CUR_W-1:0]            nb;
    logic [KEY_BITS-1:0]         in_key;
    logic                        in_acc;
    logic                        out_free;
    logic                        out_load;
    logic                        key_we;
    logic                        key_re;
    logic [ADDR_W-1:0]           rd_addr;
    logic [KEY_BITS-1:0]         key_rdata;
    sbc_pkg::t_cnt_ctl           cnt_ctl;
    logic [sbc_pkg::COUNT_W-1:0] cnt_rdata;
    logic [sbc_pkg::COUNT_W-1:0] cnt_inc;
    logic [CUR_W-1:0]            cur_p1;
    logic [CUR_W-1:0]            idx_p1;
    logic                        key_above;
    logic                        idx_last;

    generate
        if (KEY_BITS <= sbc_pkg::KEY_FIELD_W) begin : g_key_trunc
            assign in_key = i_in.key_value[KEY_BITS-1:0];
        end else begin : g_key_ext
            assign in_key = {{(KEY_BITS - sbc_pkg::KEY_FIELD_W){1'b0}}, i_in.key_value};
        end
    endgenerate

    // bins in use, clamped to 1..MAX_BINS
    always_comb begin
        if (r_num_bins == '0) begin
            nb = CUR_W'(1);
        end else if (32'(r_num_bins) > MAX_BINS) begin
            nb = CUR_W'(MAX_BINS);
        end else begin
            nb = CUR_W'(r_num_bins);
        end
    end

    assign o_ready   = (r_state == sbc_pkg::ST_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign out_free  = !r_out_vld || i_ready;
    assign cur_p1    = r_cur + CUR_W'(1);
    assign idx_p1    = r_idx + CUR_W'(1);
    assign key_above = r_key > key_rdata;
    assign idx_last  = (idx_p1 == nb);
    assign cnt_inc   = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + sbc_pkg::COUNT_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.mode == sbc_pkg::MODE_COUNT && r_cur < nb) begin
                        n_state = sbc_pkg::ST_SEEK;
                    end else if (i_in.mode == sbc_pkg::MODE_EMIT) begin
                        n_state = sbc_pkg::ST_EMIT_RD;
                    end
                end
            end
            sbc_pkg::ST_SEEK: begin
                if (!key_above || !(cur_p1 < nb)) begin
                    n_state = sbc_pkg::ST_IDLE;
                end
            end
            sbc_pkg::ST_EMIT_RD: begin
                n_state = sbc_pkg::ST_EMIT_WR;
            end
            sbc_pkg::ST_EMIT_WR: begin
                if (out_free) begin
                    n_state = idx_last ? sbc_pkg::ST_IDLE : sbc_pkg::ST_EMIT_RD;
                end
            end
            default: begin
                n_state = sbc_pkg::ST_IDLE;
            end
        endcase
    end

    // memory controls and datapath next values
    always_comb begin
        key_we   = 1'b0;
        key_re   = 1'b0;
        cnt_ctl  = '0;
        rd_addr  = r_cur[ADDR_W-1:0];
        n_cur    = r_cur;
        n_idx    = r_idx;
        n_key    = r_key;
        out_load = 1'b0;
        case (r_state)
            sbc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (i_in.mode)
                        sbc_pkg::MODE_LOAD: begin
                            key_we = (32'(i_in.splitter_index) < MAX_BINS);
                        end
                        sbc_pkg::MODE_COUNT: begin
                            n_key = in_key;
                            if (r_cur < nb) begin
                                key_re        = 1'b1;
                                cnt_ctl.rd_en = 1'b1;
                            end
                        end
                        sbc_pkg::MODE_EMIT: begin
                            n_idx = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sbc_pkg::ST_SEEK: begin
                if (key_above) begin
                    // skip to the next bin, fetch its splitter and count
                    n_cur = cur_p1;
                    if (cur_p1 < nb) begin
                        key_re        = 1'b1;
                        cnt_ctl.rd_en = 1'b1;
                        rd_addr       = cur_p1[ADDR_W-1:0];
                    end
                end else begin
                    cnt_ctl.wr_en = 1'b1;
                end
            end
            sbc_pkg::ST_EMIT_RD: begin
                cnt_ctl.rd_en = 1'b1;
                rd_addr       = r_idx[ADDR_W-1:0];
            end
            sbc_pkg::ST_EMIT_WR: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (idx_last) begin
                        cnt_ctl.clr_all = 1'b1;
                        n_cur           = '0;
                    end else begin
                        n_idx = idx_p1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sbc_pkg::ST_IDLE;
            r_num_bins <= sbc_pkg::NBINS_W'(1);
            r_cur      <= '0;
            r_idx      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                r_num_bins <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (out_load) begin
            r_out.bin_index <= sbc_pkg::BIN_IDX_W'(r_idx);
            r_out.bin_count <= cnt_rdata;
            r_out.last_bin  <= idx_last;
        end
    end

    sbc_key_mem #(
        .WIDTH  (KEY_BITS),
        .DEPTH  (MAX_BINS),
        .ADDR_W (ADDR_W)
    ) u_key_mem (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (i_in.splitter_index[ADDR_W-1:0]),
        .i_wdata (in_key),
        .i_re    (key_re),
        .i_raddr (rd_addr),
        .o_rdata (key_rdata)
    );

    sbc_cnt_mem #(
        .DEPTH  (MAX_BINS),
        .ADDR_W (ADDR_W)
    ) u_cnt_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cnt_ctl),
        .i_waddr (r_cur[ADDR_W-1:0]),
        .i_wdata (cnt_inc),
        .i_raddr (rd_addr),
        .o_rdata (cnt_rdata)
    );

    assign o_valid = r_out_vld;
    assign o_out   = r_out;

endmodule

`default_nettype wire

[sv/sbc_key_mem.sv]
// splitter key memory, one write port and one registered read port
`default_nettype none

module sbc_key_mem #(
    parameter int WIDTH  = 63,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/sbc_cnt_mem.sv]
// bin count memory with per-entry valid bits, unwritten entries read as zero
`default_nettype none

module sbc_cnt_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire sbc_pkg::t_cnt_ctl          i_ctl,
    input  wire logic [ADDR_W-1:0]          i_waddr,
    input  wire logic [sbc_pkg::COUNT_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0]          i_raddr,
    output logic      [sbc_pkg::COUNT_W-1:0] o_rdata
);

    logic [sbc_pkg::COUNT_W-1:0] r_mem [DEPTH];
    logic [sbc_pkg::COUNT_W-1:0] r_rdata;
    logic [DEPTH-1:0]            r_vld;
    logic                        r_rdata_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_rdata_vld <= 1'b0;
        end else begin
            if (i_ctl.clr_all) begin
                r_vld <= '0;
            end else if (i_ctl.wr_en) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rdata_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata_vld ? r_rdata : '0;

endmodule

`default_nettype wire

[sv/sbc_checker.sv]
// port-level checks for the splitter bin counter, bound to the top level
`default_nettype none

module sbc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire sbc_pkg::t_in_item  i_in,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire sbc_pkg::t_out_item o_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out))
        else $error("result changed while stalled");

    // an emit transaction keeps the input side busy in the next cycle
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_in.mode == sbc_pkg::MODE_EMIT |=> !o_ready)
        else $error("input accepted right after emit");

    // loads and counts never produce a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_in.mode != sbc_pkg::MODE_EMIT && !o_valid
        |=> !o_valid)
        else $error("result without emit");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind splitter_bin_counter sbc_checker u_sbc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_in    (i_in),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_out   (o_out)
);

`default_nettype wire
